// File: hdl/kchc_pkg.sv
// Key click/hold/combination classifier: shared constants, event codes and types.
// No dependencies; used by every other file of the block.
package kchc_pkg;

    localparam int NUM_KEYS   = 4;
    localparam int TICK_WIDTH = 12;
    localparam int KEY_W      = $clog2(NUM_KEYS);
    localparam int CNT_W      = 3;
    localparam int TABLE_W    = NUM_KEYS * TICK_WIDTH;
    localparam int CODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [CODE_W-1:0] EV_SHORT     = 3'd0;
    localparam logic [CODE_W-1:0] EV_LONG      = 3'd1;
    localparam logic [CODE_W-1:0] EV_HOLD_DOWN = 3'd2;
    localparam logic [CODE_W-1:0] EV_HOLD_UP   = 3'd3;
    localparam logic [CODE_W-1:0] EV_COMBO     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MASK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBO_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBO_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS   = 3'd4;

    typedef struct packed {
        logic [CODE_W-1:0]   event_code;
        logic [KEY_W-1:0]    key_index;
        logic [NUM_KEYS-1:0] combo_keys;
        logic                last_event;
    } t_event;

endpackage

// File: hdl/kchc_if.sv
// Handshake channel interfaces: key samples in, events out, configuration writes.
// Depends on kchc_pkg.
interface kchc_key_if;
    logic                          valid;
    logic                          ready;
    logic [kchc_pkg::NUM_KEYS-1:0] key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface

interface kchc_evt_if;
    logic                          valid;
    logic                          ready;
    logic [kchc_pkg::CODE_W-1:0]   event_code;
    logic [kchc_pkg::KEY_W-1:0]    key_index;
    logic [kchc_pkg::NUM_KEYS-1:0] combo_keys;
    logic                          last_event;

    modport source (output valid, output event_code, output key_index,
                    output combo_keys, output last_event, input ready);
    modport sink   (input valid, input event_code, input key_index,
                    input combo_keys, input last_event, output ready);
endinterface

interface kchc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [kchc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [kchc_pkg::CFG_DATA_W-1:0] cfg_data;

    modport source (output valid, output cfg_index, output cfg_data, input ready);
    modport sink   (input valid, input cfg_index, input cfg_data, output ready);
endinterface

// File: hdl/kchc_front.sv
// Front end: config registers, per-key state, one key per cycle (stalls on a full queue) then the combination check.
// Holds back one event so the final event of a tick can be flagged. Depends on kchc_pkg, kchc_if.
module kchc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    kchc_key_if.sink         i_key,
    kchc_cfg_if.sink         i_cfg,
    output logic             o_push,
    output kchc_pkg::t_event o_push_data,
    input  logic             i_full
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_COMBO,
        ST_FLUSH
    } t_state;

    t_state r_state, n_state;

    logic [kchc_pkg::CNT_W-1:0]    r_key_count;
    logic [kchc_pkg::NUM_KEYS-1:0] r_hold_mask;
    logic                          r_combo_en;
    logic [kchc_pkg::NUM_KEYS-1:0] r_combo_mask;
    logic [kchc_pkg::TABLE_W-1:0]  r_long_ticks;

    logic [kchc_pkg::NUM_KEYS-1:0]   r_down, n_down;
    logic [kchc_pkg::NUM_KEYS-1:0]   r_claimed, n_claimed;
    logic [kchc_pkg::TICK_WIDTH-1:0] r_ticks [kchc_pkg::NUM_KEYS];
    logic [kchc_pkg::TICK_WIDTH-1:0] n_ticks [kchc_pkg::NUM_KEYS];
    logic [kchc_pkg::NUM_KEYS-1:0]   r_levels, n_levels;
    logic [kchc_pkg::KEY_W-1:0]      r_k, n_k;
    kchc_pkg::t_event                r_held, n_held;
    logic                            r_held_valid, n_held_valid;

    logic [kchc_pkg::CNT_W-1:0]      used;
    logic                            key_active;
    logic [kchc_pkg::TICK_WIDTH-1:0] thr;
    logic [kchc_pkg::TICK_WIDTH-1:0] cnt;
    logic                            k_down;
    logic [kchc_pkg::TICK_WIDTH-1:0] k_ticks;
    logic                            k_clr;
    logic                            k_ev;
    logic [kchc_pkg::CODE_W-1:0]     k_code;
    logic                            combo_fire;
    logic                            ev_valid;
    kchc_pkg::t_event                ev;
    logic                            go;

    assign i_cfg.ready = 1'b1;
    assign i_key.ready = (r_state == ST_IDLE);

    assign used = (r_key_count > kchc_pkg::CNT_W'(kchc_pkg::NUM_KEYS))
                ? kchc_pkg::CNT_W'(kchc_pkg::NUM_KEYS) : r_key_count;
    assign key_active = (kchc_pkg::CNT_W'(r_k) < used);
    assign thr = r_long_ticks[r_k*kchc_pkg::TICK_WIDTH +: kchc_pkg::TICK_WIDTH];
    assign cnt = r_ticks[r_k];
    assign combo_fire = r_combo_en && (|r_combo_mask)
                      && ((r_combo_mask & (r_claimed | ~r_down)) == '0);

    // classification of the current key
    always_comb begin
        k_down  = r_down[r_k];
        k_ticks = cnt;
        k_clr   = 1'b0;
        k_ev    = 1'b0;
        k_code  = kchc_pkg::EV_SHORT;
        if (r_hold_mask[r_k]) begin
            if (r_levels[r_k] && !r_down[r_k]) begin
                k_down = 1'b1;
                k_ev   = 1'b1;
                k_code = kchc_pkg::EV_HOLD_DOWN;
            end else if (!r_levels[r_k] && r_down[r_k]) begin
                k_down = 1'b0;
                k_ev   = 1'b1;
                k_code = kchc_pkg::EV_HOLD_UP;
            end
        end else if (r_levels[r_k]) begin
            k_down = 1'b1;
            if (cnt < thr) begin
                k_ticks = cnt + 1'b1;
                if (!r_claimed[r_k] && (k_ticks >= thr)) begin
                    k_ev   = 1'b1;
                    k_code = kchc_pkg::EV_LONG;
                end
            end
        end else if (r_down[r_k]) begin
            k_down  = 1'b0;
            k_ticks = '0;
            k_clr   = 1'b1;
            if ((cnt < thr) && !r_claimed[r_k]) begin
                k_ev   = 1'b1;
                k_code = kchc_pkg::EV_SHORT;
            end
        end
    end

    always_comb begin
        ev_valid = 1'b0;
        ev       = '0;
        if (r_state == ST_KEY && key_active && k_ev) begin
            ev_valid      = 1'b1;
            ev.event_code = k_code;
            ev.key_index  = r_k;
        end else if (r_state == ST_COMBO && combo_fire) begin
            ev_valid      = 1'b1;
            ev.event_code = kchc_pkg::EV_COMBO;
            ev.combo_keys = r_combo_mask;
        end
    end

    assign go = !(ev_valid && r_held_valid && i_full);

    always_comb begin
        n_state      = r_state;
        n_down       = r_down;
        n_claimed    = r_claimed;
        n_ticks      = r_ticks;
        n_levels     = r_levels;
        n_k          = r_k;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        o_push       = 1'b0;
        o_push_data  = r_held;
        o_push_data.last_event = (r_state == ST_FLUSH);

        if (go && ev_valid) begin
            o_push       = r_held_valid;
            n_held       = ev;
            n_held_valid = 1'b1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_key.valid) begin
                    n_levels = i_key.key_levels;
                    n_k      = '0;
                    n_state  = ST_KEY;
                end
            end
            ST_KEY: begin
                if (go) begin
                    if (key_active) begin
                        n_down[r_k]  = k_down;
                        n_ticks[r_k] = k_ticks;
                        if (k_clr) begin
                            n_claimed[r_k] = 1'b0;
                        end
                    end
                    if (r_k == kchc_pkg::KEY_W'(kchc_pkg::NUM_KEYS - 1)) begin
                        n_state = ST_COMBO;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            ST_COMBO: begin
                if (go) begin
                    if (combo_fire) begin
                        n_claimed = r_claimed | r_combo_mask;
                    end
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_held_valid) begin
                    n_state = ST_IDLE;
                end else if (!i_full) begin
                    o_push       = 1'b1;
                    n_held_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_down       <= '0;
            r_claimed    <= '0;
            r_held_valid <= 1'b0;
            r_k          <= '0;
            r_key_count  <= '0;
            r_hold_mask  <= '0;
            r_combo_en   <= 1'b0;
            r_combo_mask <= '0;
            r_long_ticks <= '0;
            for (int i = 0; i < kchc_pkg::NUM_KEYS; i++) begin
                r_ticks[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_down       <= n_down;
            r_claimed    <= n_claimed;
            r_held_valid <= n_held_valid;
            r_k          <= n_k;
            r_ticks      <= n_ticks;
            if (i_cfg.valid) begin
                unique case (i_cfg.cfg_index)
                    kchc_pkg::CFG_KEY_COUNT:
                        r_key_count <= i_cfg.cfg_data[kchc_pkg::CNT_W-1:0];
                    kchc_pkg::CFG_HOLD_MASK:
                        r_hold_mask <= i_cfg.cfg_data[kchc_pkg::NUM_KEYS-1:0];
                    kchc_pkg::CFG_COMBO_ENABLE:
                        r_combo_en <= i_cfg.cfg_data[0];
                    kchc_pkg::CFG_COMBO_MASK:
                        r_combo_mask <= i_cfg.cfg_data[kchc_pkg::NUM_KEYS-1:0];
                    kchc_pkg::CFG_LONG_TICKS:
                        r_long_ticks <= i_cfg.cfg_data[kchc_pkg::TABLE_W-1:0];
                    default: ;
                endcase
            end
        end
        r_levels <= n_levels;
        r_held   <= n_held;
    end

endmodule

// File: hdl/kchc_fifo.sv
// Event queue between front and back end: small register file with fill count.
// Depends on kchc_pkg.
module kchc_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kchc_pkg::t_event i_data,
    output logic             o_full,
    input  logic             i_pop,
    output kchc_pkg::t_event o_data,
    output logic             o_empty
);

    kchc_pkg::t_event                r_mem [kchc_pkg::FIFO_DEPTH];
    logic [kchc_pkg::FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [kchc_pkg::FIFO_PTR_W:0]   r_count;

    assign o_full  = (r_count == (kchc_pkg::FIFO_PTR_W+1)'(kchc_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/kchc_back.sv
// Back end: pulls events from the queue into the output register and drives the event channel.
// Depends on kchc_pkg, kchc_if.
module kchc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  kchc_pkg::t_event i_data,
    output logic             o_pop,
    kchc_evt_if.source       o_evt
);

    logic             r_valid;
    kchc_pkg::t_event r_data;

    assign o_pop = !i_empty && (!r_valid || o_evt.ready);

    assign o_evt.valid      = r_valid;
    assign o_evt.event_code = r_data.event_code;
    assign o_evt.key_index  = r_data.key_index;
    assign o_evt.combo_keys = r_data.combo_keys;
    assign o_evt.last_event = r_data.last_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_data <= i_data;
        end
    end

endmodule

// File: hdl/key_click_hold_combo_classifier_core.sv
// Key click/hold/combination classifier, top level.
// A tick passes through accept, one key per cycle, the combination check and flush;
// a new tick on i_key is accepted only back in idle, and a step stalls while the
// 4-entry event queue is full and that step has a held event to push.
// Reset (synchronous, active low) clears config registers, key state and the queue.
// Depends on kchc_pkg, kchc_if, kchc_front, kchc_fifo, kchc_back.
module key_click_hold_combo_classifier_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kchc_key_if.sink   i_key,
    kchc_cfg_if.sink   i_cfg,
    kchc_evt_if.source o_evt
);

    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    kchc_pkg::t_event push_data;
    kchc_pkg::t_event pop_data;

    kchc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (i_key),
        .i_cfg       (i_cfg),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    kchc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_empty (empty)
    );

    kchc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_data  (pop_data),
        .o_pop   (pop),
        .o_evt   (o_evt)
    );

endmodule
